FILE: sv/assert_macros.svh
// Assertion macros shared by the reorder buffer RTL.
// Depends on nothing; each macro takes the clock and active-low reset by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/srb_pkg.sv
// Package for the sequence reorder buffer: field widths, status codes,
// and the result record passed from the sequencer to the output buffer.
package srb_pkg;

  localparam int SEQ_W      = 16;
  localparam int PLD_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int RESULT_CAP = 16;
  localparam int CNT_W      = $clog2(RESULT_CAP + 1);

  localparam logic [STATUS_W-1:0] STS_RELEASED  = 2'd0;
  localparam logic [STATUS_W-1:0] STS_DONE      = 2'd1;
  localparam logic [STATUS_W-1:0] STS_OUT_OF_WIN = 2'd2;
  localparam logic [STATUS_W-1:0] STS_DUPLICATE = 2'd3;

  typedef struct packed {
    logic [PLD_W-1:0]    payload;
    logic [SEQ_W-1:0]    seq;
    logic [STATUS_W-1:0] status;
    logic                last;
  } res_t;

endpackage

FILE: sv/srb_out_buf.sv
// Two-entry result queue between the reorder sequencer and the output port.
// Depends on srb_pkg (res_t) and assert_macros.svh.
`include "assert_macros.svh"

module srb_out_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  srb_pkg::res_t push_data,
  output logic          push_ready,
  output logic          out_valid,
  input  logic          out_stall,
  output srb_pkg::res_t out_data
);

  srb_pkg::res_t ent_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          pop;

  assign out_valid  = (cnt_r != 2'd0);
  assign push_ready = (cnt_r != 2'd2);
  assign out_data   = ent_r[rd_ptr_r];
  assign pop        = out_valid && !out_stall;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold payload entries; no reset needed.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  `ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r != 2'd3, "queue count out of range")
  `ASSERT_IMP(a_no_overflow, clk, rst_n, push, cnt_r != 2'd2, "push into a full queue")
  `ASSERT_NXT(a_pop_drains, clk, rst_n, pop && !push, cnt_r == $past(cnt_r) - 2'd1,
              "pop did not reduce the count")

endmodule

FILE: sv/sequence_reorder_buffer.sv
// Sequence reorder buffer top level: window sequencer and slot payload memory.
// Depends on srb_pkg, srb_out_buf and assert_macros.svh.
//
// Work items arrive out of order, each tagged with a 16-bit sequence number,
// and leave strictly in sequence order. An item whose distance from the
// expected number is below WINDOW_DEPTH is parked in a ring slot of the
// payload memory; every parked item that is now consecutive from the
// expected number is then released (status 0), at most 16 per request, the
// last one carrying last_of_run. A request outside the window (status 2) or
// aimed at an occupied slot (status 3) is dropped with one error result; a
// stop request gives one done result (status 1) carrying the expected number
// and leaves the window as it is. A stored request that completes no run
// gives no result. A request is taken in IDLE and evaluated in EVAL in the
// next cycle; a stop or an error is answered there. A stored item goes on
// to READ, which checks the head slot. Each released item is read in READ
// from the registered read port of the payload memory and emitted in EMIT,
// the read of the first one taking the place of the head check. Results go
// into a two-entry queue, so a stalled output does not hold the next request
// back until that queue is full. No clearing pass is needed after reset:
// slot occupancy lives in flip-flops that reset clears at once.
`include "assert_macros.svh"

module sequence_reorder_buffer #(
  parameter int WINDOW_DEPTH = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [srb_pkg::SEQ_W-1:0]     in_item_seq,
  input  logic [srb_pkg::PLD_W-1:0]     in_item_payload,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [srb_pkg::PLD_W-1:0]     out_payload,
  output logic [srb_pkg::SEQ_W-1:0]     out_seq,
  output logic [srb_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_last_of_run
);

  localparam int SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int EXT_W  = (PAYLOAD_BITS > srb_pkg::PLD_W) ? PAYLOAD_BITS : srb_pkg::PLD_W;

  // Window depth, last slot and last release count at the widths they are compared against.
  localparam logic [srb_pkg::SEQ_W-1:0] DEPTH_SEQ = WINDOW_DEPTH[srb_pkg::SEQ_W-1:0];
  localparam logic [SLOT_W:0]           DEPTH_SUM = WINDOW_DEPTH[SLOT_W:0];
  localparam logic [SLOT_W-1:0]         HEAD_LAST = SLOT_W'(WINDOW_DEPTH - 1);
  localparam logic [srb_pkg::CNT_W-1:0] CNT_LAST  = srb_pkg::CNT_W'(srb_pkg::RESULT_CAP - 1);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;  // wait for a request
  localparam logic [1:0] ST_EVAL = 2'd1;  // classify, store or answer
  localparam logic [1:0] ST_READ = 2'd2;  // read the head slot
  localparam logic [1:0] ST_EMIT = 2'd3;  // release the head slot

  logic [1:0]                    state_r, state_nxt;
  logic [WINDOW_DEPTH-1:0]       slot_valid_r, slot_valid_nxt;
  logic [srb_pkg::SEQ_W-1:0]     exp_seq_r, exp_seq_nxt;
  logic [SLOT_W-1:0]             head_r, head_nxt;
  logic [srb_pkg::CNT_W-1:0]     rel_cnt_r, rel_cnt_nxt;

  // Latched request; payload registers carry no reset.
  logic                          req_kind_r;
  logic [srb_pkg::SEQ_W-1:0]     req_seq_r;
  logic [srb_pkg::PLD_W-1:0]     req_payload_r;

  // Slot payload memory: one write port, one registered read port.
  logic [PAYLOAD_BITS-1:0]       slot_mem [WINDOW_DEPTH];
  logic [PAYLOAD_BITS-1:0]       mem_rd_data_r;
  logic                          mem_we;
  logic                          mem_re;
  logic [EXT_W-1:0]              wr_ext;
  logic [EXT_W-1:0]              rd_ext;

  logic [srb_pkg::SEQ_W-1:0]     seq_dist;
  logic                          in_win;
  logic [SLOT_W:0]               slot_sum;
  logic [SLOT_W-1:0]             tgt_slot;
  logic [SLOT_W-1:0]             head_inc;
  logic                          run_last;

  logic                          res_push;
  logic                          res_ready;
  srb_pkg::res_t                 res;
  srb_pkg::res_t                 out_res;

  // Take a request only while the sequencer is idle.
  assign in_stall = (state_r != ST_IDLE);

  // Distance from the expected number, and the ring slot it lands in.
  assign seq_dist = req_seq_r - exp_seq_r;
  assign in_win   = (seq_dist < DEPTH_SEQ);
  assign slot_sum = {1'b0, head_r} + {1'b0, seq_dist[SLOT_W-1:0]};
  assign tgt_slot = (slot_sum >= DEPTH_SUM) ? SLOT_W'(slot_sum - DEPTH_SUM)
                                            : slot_sum[SLOT_W-1:0];
  assign head_inc = (head_r == HEAD_LAST) ? '0 : head_r + 1'b1;

  // A release ends the run when the next slot is empty or the cap is hit.
  assign run_last = !slot_valid_r[head_inc] || (rel_cnt_r == CNT_LAST);

  // Stored payloads are kept to PAYLOAD_BITS and leave as 32-bit words.
  assign wr_ext = EXT_W'(req_payload_r);
  assign rd_ext = EXT_W'(mem_rd_data_r);

  always_comb begin
    state_nxt      = state_r;
    slot_valid_nxt = slot_valid_r;
    exp_seq_nxt    = exp_seq_r;
    head_nxt       = head_r;
    rel_cnt_nxt    = rel_cnt_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    res_push       = 1'b0;
    res            = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        priority if (req_kind_r) begin
          // Stop: answer with the expected number, leave the window alone.
          res.seq    = exp_seq_r;
          res.status = srb_pkg::STS_DONE;
          res.last   = 1'b1;
          res_push   = res_ready;
        end else if (!in_win) begin
          res.seq    = req_seq_r;
          res.status = srb_pkg::STS_OUT_OF_WIN;
          res.last   = 1'b1;
          res_push   = res_ready;
        end else if (slot_valid_r[tgt_slot]) begin
          res.seq    = req_seq_r;
          res.status = srb_pkg::STS_DUPLICATE;
          res.last   = 1'b1;
          res_push   = res_ready;
        end else begin
          // Park the item, then try to drain from the head.
          mem_we                   = 1'b1;
          slot_valid_nxt[tgt_slot] = 1'b1;
          rel_cnt_nxt              = '0;
          state_nxt                = ST_READ;
        end
        if (res_push) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        if (slot_valid_r[head_r]) begin
          mem_re    = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        res.payload = rd_ext[srb_pkg::PLD_W-1:0];
        res.seq     = exp_seq_r;
        res.status  = srb_pkg::STS_RELEASED;
        res.last    = run_last;
        if (res_ready) begin
          // Release the head slot and advance the window.
          res_push               = 1'b1;
          slot_valid_nxt[head_r] = 1'b0;
          exp_seq_nxt            = exp_seq_r + 1'b1;
          head_nxt               = head_inc;
          rel_cnt_nxt            = rel_cnt_r + 1'b1;
          state_nxt              = run_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      slot_valid_r <= '0;
      exp_seq_r    <= '0;
      head_r       <= '0;
      rel_cnt_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      slot_valid_r <= slot_valid_nxt;
      exp_seq_r    <= exp_seq_nxt;
      head_r       <= head_nxt;
      rel_cnt_r    <= rel_cnt_nxt;
    end
  end

  // Capture the request on acceptance.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_kind_r    <= in_kind;
      req_seq_r     <= in_item_seq;
      req_payload_r <= in_item_payload;
    end
  end

  // Write in EVAL and read in READ never meet in one cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[tgt_slot] <= wr_ext[PAYLOAD_BITS-1:0];
    end
    if (mem_re) begin
      mem_rd_data_r <= slot_mem[head_r];
    end
  end

  srb_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_push),
    .push_data  (res),
    .push_ready (res_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_res)
  );

  assign out_payload     = out_res.payload;
  assign out_seq         = out_res.seq;
  assign out_status      = out_res.status;
  assign out_last_of_run = out_res.last;

  `ASSERT_IMP(a_push_state, clk, rst_n, res_push,
              (state_r == ST_EVAL) || (state_r == ST_EMIT), "result pushed outside EVAL/EMIT")
  `ASSERT_IMP(a_emit_valid, clk, rst_n, state_r == ST_EMIT, slot_valid_r[head_r],
              "release of an empty slot")
  `ASSERT_NXT(a_seq_advance, clk, rst_n, (state_r == ST_EMIT) && res_push,
              (exp_seq_r == $past(exp_seq_r) + 1'b1) && !slot_valid_r[$past(head_r)],
              "release did not advance the window")
  `ASSERT_IMP(a_cap, clk, rst_n, state_r == ST_EMIT, rel_cnt_r <= CNT_LAST,
              "release count beyond the cap")
  `ASSERT_IMP(a_head_range, clk, rst_n, 1'b1, head_r <= HEAD_LAST, "head slot out of range")

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// Testbench for sequence_reorder_buffer: a directed table and then shuffled
// sequence runs, each result checked against a window model. Depends on srb_pkg.
module testbench;

  localparam int SEQ_W = srb_pkg::SEQ_W;
  localparam int PLD_W = srb_pkg::PLD_W;
  localparam int STATUS_W = srb_pkg::STATUS_W;
  localparam int RESULT_CAP = srb_pkg::RESULT_CAP;

  localparam int WINDOW_DEPTH = 16;
  localparam int RANDOM_ITEMS = 360;
  localparam int QUIET_TAIL = 60;      // last requests run with no idling
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES = 48;   // longest request releases RESULT_CAP items
  localparam int CYCLE_LIMIT = 300000;

  localparam logic KIND_WORK = 1'b0;
  localparam logic KIND_STOP = 1'b1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = KIND_WORK;
  logic [SEQ_W-1:0] in_item_seq = '0;
  logic [PLD_W-1:0] in_item_payload = '0;

  logic out_valid;
  logic out_stall = 1'b0;
  logic [PLD_W-1:0] out_payload;
  logic [SEQ_W-1:0] out_seq;
  logic [STATUS_W-1:0] out_status;
  logic out_last_of_run;

  // Typed result that travels with a directed request, when it has one.
  bit req_typed = 1'b0;
  srb_pkg::res_t req_typed_result = '0;

  typedef struct {
    logic kind;
    logic [SEQ_W-1:0] seq;
    logic [PLD_W-1:0] payload;
    bit typed;
    srb_pkg::res_t result;
  } stim_row_t;

  stim_row_t stim_table[$];
  srb_pkg::res_t due_results[$];

  // Window model: parked slots, next number to release, ring head.
  bit parked[WINDOW_DEPTH];
  logic [PLD_W-1:0] parked_payload[WINDOW_DEPTH];
  logic [SEQ_W-1:0] next_seq = '0;
  int head_slot = 0;

  int mismatch_count = 0;
  int sent_count = 0;
  int total_items = 0;
  int cycle_count = 0;
  bit idling_on = 1'b1;
  bit hold_request = 1'b0;

  int depth_before;
  srb_pkg::res_t want;

  sequence_reorder_buffer DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_item_seq(in_item_seq),
    .in_item_payload(in_item_payload),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_payload(out_payload),
    .out_seq(out_seq),
    .out_status(out_status),
    .out_last_of_run(out_last_of_run)
  );

  always #2 clk = ~clk;

  // Abort on a hang: a missing result or a stuck stall shows up here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sequence_reorder_buffer test failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [PLD_W-1:0] exp_val,
                                 input logic [PLD_W-1:0] got_val);
    $display("mismatch at cycle %0d: %s expected %0h got %0h",
             cycle_count, what, exp_val, got_val);
    mismatch_count++;
  endtask

  // Park the request in its ring slot, then release the run that starts at
  // next_seq, at most RESULT_CAP per request. Stop and errors leave the
  // window untouched.
  task automatic reorder_predict(input logic kind, input logic [SEQ_W-1:0] seq,
                                 input logic [PLD_W-1:0] payload);
    logic [SEQ_W-1:0] seq_dist;
    int slot;
    int released;
    srb_pkg::res_t r;
    released = 0;
    seq_dist = seq - next_seq;
    if (kind == KIND_STOP) begin
      r = {{PLD_W{1'b0}}, next_seq, srb_pkg::STS_DONE, 1'b1};
      due_results.push_back(r);
    end else if (seq_dist >= WINDOW_DEPTH) begin
      r = {{PLD_W{1'b0}}, seq, srb_pkg::STS_OUT_OF_WIN, 1'b1};
      due_results.push_back(r);
    end else begin
      slot = (head_slot + seq_dist) % WINDOW_DEPTH;
      if (parked[slot]) begin
        r = {{PLD_W{1'b0}}, seq, srb_pkg::STS_DUPLICATE, 1'b1};
        due_results.push_back(r);
      end else begin
        parked[slot] = 1'b1;
        parked_payload[slot] = payload;
        while (released < RESULT_CAP && parked[head_slot]) begin
          r = {parked_payload[head_slot], next_seq, srb_pkg::STS_RELEASED, 1'b0};
          due_results.push_back(r);
          parked[head_slot] = 1'b0;
          next_seq = next_seq + 1'b1;
          head_slot = (head_slot + 1) % WINDOW_DEPTH;
          released++;
        end
        // Mark the end of the run on its final release.
        if (released > 0) begin
          r = due_results.pop_back();
          r.last = 1'b1;
          due_results.push_back(r);
        end
      end
    end
  endtask

  // Predict every accepted request and check every accepted result against
  // the oldest one still awaited. Results lag requests by the request register
  // and the result queue, so the push never serves a pop at the same edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      depth_before = due_results.size();
      reorder_predict(in_kind, in_item_seq, in_item_payload);
      // A directed row with a typed result replaces what the model gave.
      if (req_typed) begin
        while (due_results.size() > depth_before)
          void'(due_results.pop_back());
        due_results.push_back(req_typed_result);
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        report_mismatch("result with none awaited, seq", '0, PLD_W'(out_seq));
      end else begin
        want = due_results.pop_front();
        if (out_payload !== want.payload)
          report_mismatch("out_payload", want.payload, out_payload);
        if (out_seq !== want.seq)
          report_mismatch("out_seq", PLD_W'(want.seq), PLD_W'(out_seq));
        if (out_status !== want.status)
          report_mismatch("out_status", PLD_W'(want.status), PLD_W'(out_status));
        if (out_last_of_run !== want.last)
          report_mismatch("out_last_of_run", PLD_W'(want.last), PLD_W'(out_last_of_run));
      end
    end
  end

  // Receiver: random stall bursts while idling is on; one long hold-off on
  // request from the sender so the block fills up and stalls its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_request = 1'b0;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic add_row(input logic kind, input logic [SEQ_W-1:0] seq,
                         input logic [PLD_W-1:0] payload, input bit typed,
                         input logic [STATUS_W-1:0] status,
                         input logic [SEQ_W-1:0] res_seq);
    stim_row_t row;
    row.kind = kind;
    row.seq = seq;
    row.payload = payload;
    row.typed = typed;
    row.result = {{PLD_W{1'b0}}, res_seq, status, 1'b1};
    stim_table.push_back(row);
  endtask

  // Offer one request and hold it until accepted. Lower valid for a gap only
  // while a request is on offer.
  task automatic send_request(input logic kind, input logic [SEQ_W-1:0] seq,
                              input logic [PLD_W-1:0] payload, input bit typed,
                              input srb_pkg::res_t typed_res);
    if (in_valid && idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_item_seq <= seq;
    in_item_payload <= payload;
    req_typed <= typed;
    req_typed_result <= typed_res;
    do @(posedge clk); while (in_stall);
    sent_count++;
    // Alternate stretches with and without idling; none in the tail.
    idling_on = (sent_count < total_items - QUIET_TAIL) && ((sent_count / 40) % 3 != 2);
  endtask

  initial begin
    int n;
    int k;
    int tmp;
    int pick;
    int order[WINDOW_DEPTH];
    logic [SEQ_W-1:0] issue_base;
    bit hold_done;
    bit drain_done;

    hold_done = 1'b0;
    drain_done = 1'b0;

    // Directed table. Typed results where obvious: stop, window edges,
    // duplicates. Releases come from the model.
    add_row(KIND_STOP, 16'h0000, 32'h0000_0000, 1'b1, srb_pkg::STS_DONE, 16'd0);
    add_row(KIND_WORK, 16'd16, 32'h1234_5678, 1'b1, srb_pkg::STS_OUT_OF_WIN, 16'd16);
    add_row(KIND_WORK, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, srb_pkg::STS_OUT_OF_WIN, 16'hFFFF);
    add_row(KIND_WORK, 16'd2, 32'hFFFF_FFFF, 1'b0, srb_pkg::STS_RELEASED, 16'd0);
    add_row(KIND_WORK, 16'd2, 32'h0000_0001, 1'b1, srb_pkg::STS_DUPLICATE, 16'd2);
    add_row(KIND_WORK, 16'd15, 32'h0000_0000, 1'b0, srb_pkg::STS_RELEASED, 16'd0);
    add_row(KIND_WORK, 16'd1, 32'hA5A5_A5A5, 1'b0, srb_pkg::STS_RELEASED, 16'd0);
    add_row(KIND_WORK, 16'd0, 32'h0000_0000, 1'b0, srb_pkg::STS_RELEASED, 16'd0);
    add_row(KIND_STOP, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, srb_pkg::STS_DONE, 16'd3);
    // Fill the whole window behind seq 3, then release all 16 at once.
    for (int s = 14; s >= 4; s--)
      add_row(KIND_WORK, s[SEQ_W-1:0], 32'h5A5A_0000 | s, 1'b0, srb_pkg::STS_RELEASED, 16'd0);
    add_row(KIND_WORK, 16'd16, 32'h8000_0000, 1'b0, srb_pkg::STS_RELEASED, 16'd0);
    add_row(KIND_WORK, 16'd17, 32'h7FFF_FFFF, 1'b0, srb_pkg::STS_RELEASED, 16'd0);
    add_row(KIND_WORK, 16'd18, 32'hFFFF_FFFF, 1'b0, srb_pkg::STS_RELEASED, 16'd0);
    add_row(KIND_WORK, 16'd3, 32'h0000_0003, 1'b0, srb_pkg::STS_RELEASED, 16'd0);
    add_row(KIND_STOP, 16'h0000, 32'h0000_0000, 1'b1, srb_pkg::STS_DONE, 16'd19);
    add_row(KIND_WORK, 16'd35, 32'hDEAD_BEEF, 1'b1, srb_pkg::STS_OUT_OF_WIN, 16'd35);

    total_items = stim_table.size() + RANDOM_ITEMS;

    // Hold reset at the start, then release it once for the whole run.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i])
      send_request(stim_table[i].kind, stim_table[i].seq, stim_table[i].payload,
                   stim_table[i].typed, stim_table[i].result);

    // Random part: shuffled runs of consecutive numbers from the release
    // point, with stray, duplicate and stop requests mixed in.
    issue_base = 16'd19;
    while (sent_count < total_items) begin
      if (!hold_done && sent_count >= 120) begin
        hold_request = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && sent_count >= 230) begin
        // Pause the sender until every awaited result is out.
        in_valid <= 1'b0;
        do @(posedge clk); while (due_results.size() != 0);
        drain_done = 1'b1;
      end
      n = ($urandom_range(0, 7) == 0) ? WINDOW_DEPTH : $urandom_range(1, 8);
      for (int i = 0; i < n; i++)
        order[i] = i;
      for (int i = n - 1; i > 0; i--) begin
        k = $urandom_range(0, i);
        tmp = order[i];
        order[i] = order[k];
        order[k] = tmp;
      end
      for (int j = 0; j < n; j++) begin
        pick = $urandom_range(0, 19);
        if (pick < 2)
          send_request(KIND_WORK, SEQ_W'($urandom_range(0, 65535)), $urandom, 1'b0, '0);
        else if (pick == 2 && j > 0)
          send_request(KIND_WORK, SEQ_W'(issue_base + order[$urandom_range(0, j - 1)]),
                       $urandom, 1'b0, '0);
        else if (pick == 3)
          send_request(KIND_STOP, SEQ_W'($urandom_range(0, 65535)), $urandom, 1'b0, '0);
        send_request(KIND_WORK, SEQ_W'(issue_base + order[j]), $urandom, 1'b0, '0);
      end
      issue_base = SEQ_W'(issue_base + n);
    end

    // Drop valid, drain what is awaited, then let the block settle.
    in_valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("sequence_reorder_buffer test passed");
    else
      $display("sequence_reorder_buffer test failed");
    $finish;
  end

endmodule
